>>> hdl/domino_tiling_counter_macros.svh
// Assertion macros of the domino tiling counter checker.
`ifndef DOMINO_TILING_COUNTER_MACROS_SVH
`define DOMINO_TILING_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DTC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("domino tiling counter check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DTC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("domino tiling counter check failed");

`endif

>>> hdl/dtc_pkg.sv
// Package of the domino tiling counter: sizes, controller states and command/status types.
package dtc_pkg;

	localparam int MAX_COLS = 11;
	localparam int MAX_ROWS = 11;
	localparam int SIZE_W   = 4;
	localparam int COUNT_W  = 64;
	localparam int TILE_W   = 63;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SWEEP,
		ST_DRAIN,
		ST_FETCH,
		ST_LOAD,
		ST_RESULT
	} dtc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;        // latch sizes, clear cell and profile counters
		logic issue;        // read sources of one profile, advance profile index
		logic next_cell;    // swap banks, advance to the next cell
		logic fetch;        // read the full profile of the final bank
		logic load_result;  // capture the fetched count
		logic load_special; // capture the count of a trivial size
	} dtc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic special;   // size needs no sweep
		logic prof_last; // profile index is at the full mask
		logic cell_last; // last cell of the grid
	} dtc_status_t;

endpackage

>>> hdl/dtc_if.sv
// Handshake channels of the domino tiling counter: size request and count result.
interface dtc_req_if;
	logic                      valid;
	logic                      ready;
	logic [dtc_pkg::SIZE_W-1:0] rows;
	logic [dtc_pkg::SIZE_W-1:0] cols;

	modport source (output valid, output rows, output cols, input ready);
	modport sink (input valid, input rows, input cols, output ready);
endinterface

interface dtc_res_if;
	logic                      valid;
	logic                      ready;
	logic [dtc_pkg::TILE_W-1:0] tiling_count;

	modport source (output valid, output tiling_count, input ready);
	modport sink (input valid, input tiling_count, output ready);
endinterface

>>> hdl/dtc_ctrl.sv
// Controller state machine of the domino tiling counter.
module dtc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 res_valid,
	input  logic                 res_ready,
	input  dtc_pkg::dtc_status_t status,
	output dtc_pkg::dtc_cmd_t    cmd
);
	import dtc_pkg::*;

	dtc_state_t state_q;
	dtc_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_START;
				end
			end
			ST_START: begin
				if (status.special) begin
					cmd.load_special = 1'b1;
					state_d          = ST_RESULT;
				end else begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				cmd.issue = 1'b1;
				if (status.prof_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.next_cell = 1'b1;
				if (status.cell_last) begin
					state_d = ST_FETCH;
				end else begin
					state_d = ST_SWEEP;
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load_result = 1'b1;
				state_d         = ST_RESULT;
			end
			ST_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/dtc_datapath.sv
// Datapath of the domino tiling counter: profile count memory, pull update and result register.
module dtc_datapath #(
	parameter int MaxCols = dtc_pkg::MAX_COLS,
	parameter int MaxRows = dtc_pkg::MAX_ROWS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [dtc_pkg::SIZE_W-1:0] rows,
	input  logic [dtc_pkg::SIZE_W-1:0] cols,
	input  dtc_pkg::dtc_cmd_t          cmd,
	output dtc_pkg::dtc_status_t       status,
	output logic [dtc_pkg::TILE_W-1:0] tiling_count
);
	import dtc_pkg::*;

	localparam int AddrW = MaxCols;
	localparam int Depth = 2 ** (AddrW + 1);

	// Two banks of profile counts; the top address bit picks the bank.
	logic [COUNT_W-1:0] mem [Depth];

	logic [SIZE_W-1:0] rows_q;
	logic [SIZE_W-1:0] cols_q;
	logic [SIZE_W-1:0] row_q;
	logic [SIZE_W-1:0] col_q;
	logic [AddrW-1:0]  prof_q;
	logic              bank_q;

	logic [AddrW-1:0]  full_idx;
	logic [AddrW-1:0]  top_idx;
	logic [AddrW-1:0]  half_idx;
	logic [AddrW-1:0]  a_idx;
	logic [AddrW-1:0]  b_idx;
	logic              first_cell;
	logic              zero_size;

	logic              wr_en_s1;
	logic [AddrW-1:0]  prof_s1;
	logic              first_s1;
	logic              use_a_s1;
	logic              use_b_s1;
	logic              virt_a_s1;
	logic              virt_b_s1;
	logic [COUNT_W-1:0] rd_a_s1;
	logic [COUNT_W-1:0] rd_b_s1;
	logic [COUNT_W-1:0] term_a;
	logic [COUNT_W-1:0] term_b;
	logic [COUNT_W-1:0] sum;
	logic [TILE_W-1:0]  result_q;

	// Profile masks for the current width
	assign full_idx   = ~({AddrW{1'b1}} << cols_q);
	assign top_idx    = AddrW'(1) << (cols_q - SIZE_W'(1));
	assign half_idx   = prof_q >> 1;
	assign first_cell = (row_q == '0) && (col_q == '0);

	// Sources of one destination profile: open/vertical on port A, horizontal on port B
	always_comb begin
		if (cmd.fetch) begin
			a_idx = full_idx;
		end else if (!prof_q[0]) begin
			a_idx = half_idx | top_idx;
		end else begin
			a_idx = half_idx;
		end
		b_idx = (half_idx & ~AddrW'(1)) | top_idx;
	end

	// Status toward the controller
	assign zero_size = (rows_q == '0) || (cols_q == '0);
	assign status.special = zero_size
		|| (rows_q > SIZE_W'(MaxRows)) || (cols_q > SIZE_W'(MaxCols))
		|| ((rows_q[0] & cols_q[0]) == 1'b1);
	assign status.prof_last = (prof_q == full_idx);
	assign status.cell_last = (row_q == rows_q - SIZE_W'(1))
		&& (col_q == cols_q - SIZE_W'(1));

	// Sizes, cell position, profile index and bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0;
			cols_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
			prof_q <= '0;
			bank_q <= 1'b0;
		end else if (cmd.start) begin
			rows_q <= rows;
			cols_q <= cols;
			row_q  <= '0;
			col_q  <= '0;
			prof_q <= '0;
			bank_q <= 1'b0;
		end else if (cmd.issue) begin
			prof_q <= prof_q + AddrW'(1);
		end else if (cmd.next_cell) begin
			prof_q <= '0;
			bank_q <= ~bank_q;
			if (col_q == cols_q - SIZE_W'(1)) begin
				col_q <= '0;
				row_q <= row_q + SIZE_W'(1);
			end else begin
				col_q <= col_q + SIZE_W'(1);
			end
		end
	end

	// Write enable of the update stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
		end else begin
			wr_en_s1 <= cmd.issue;
		end
	end

	// Carry the rule selects of each profile into the update stage
	always_ff @(posedge clk) begin
		prof_s1   <= prof_q;
		first_s1  <= first_cell;
		use_a_s1  <= !prof_q[0] || (row_q != '0);
		use_b_s1  <= prof_q[0] && (AddrW > 1) && prof_q[AddrW > 1 ? 1 : 0] && (col_q != '0);
		virt_a_s1 <= (a_idx == full_idx);
		virt_b_s1 <= (b_idx == full_idx);
	end

	// Read the source bank on both ports
	always_ff @(posedge clk) begin
		rd_a_s1 <= mem[{bank_q, a_idx}];
		rd_b_s1 <= mem[{bank_q, b_idx}];
	end

	// Sum the contributions; the first cell starts from the full profile alone
	always_comb begin
		if (!use_a_s1) begin
			term_a = '0;
		end else if (first_s1) begin
			term_a = COUNT_W'(virt_a_s1);
		end else begin
			term_a = rd_a_s1;
		end
		if (!use_b_s1) begin
			term_b = '0;
		end else if (first_s1) begin
			term_b = COUNT_W'(virt_b_s1);
		end else begin
			term_b = rd_b_s1;
		end
		sum = term_a + term_b;
	end

	// Write the destination bank
	always_ff @(posedge clk) begin
		if (wr_en_s1) begin
			mem[{~bank_q, prof_s1}] <= sum;
		end
	end

	// Hold the count until taken
	always_ff @(posedge clk) begin
		if (cmd.load_special) begin
			result_q <= zero_size ? TILE_W'(1) : '0;
		end else if (cmd.load_result) begin
			result_q <= rd_a_s1[TILE_W-1:0];
		end
	end

	assign tiling_count = result_q;

endmodule

>>> hdl/domino_tiling_counter.sv
// Top level of the domino tiling counter: controller, datapath and channel wiring.
//
//  channel | dir | payload              | meaning
//  req     | in  | rows[3:0], cols[3:0] | grid size to tile
//  res     | out | tiling_count[62:0]   | number of domino tilings
//
// One item at a time. A sweep of 2^cols profiles plus a drain step per cell,
// one profile per cycle through the single write port of the count memory;
// after the last cell the fetch and load states lead to res.valid.
// A zero size, an oversize or two odd sizes skip the sweep and go from the start state to the result.
// The memory needs no clearing: every profile of a bank is written before it is read.
// req.ready is high only while idle; a stalled result holds until res.ready.
module domino_tiling_counter #(
	parameter int MaxCols = dtc_pkg::MAX_COLS,
	parameter int MaxRows = dtc_pkg::MAX_ROWS
) (
	input  logic      clk,
	input  logic      arst_n,
	dtc_req_if.sink   req,
	dtc_res_if.source res
);
	import dtc_pkg::*;

	dtc_cmd_t    cmd;
	dtc_status_t status;

	// Sequence the sweep
	dtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Update the profile counts
	dtc_datapath #(
		.MaxCols (MaxCols),
		.MaxRows (MaxRows)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.rows         (req.rows),
		.cols         (req.cols),
		.cmd          (cmd),
		.status       (status),
		.tiling_count (res.tiling_count)
	);

endmodule

>>> hdl/dtc_checker.sv
// Port checker of the domino tiling counter and its bind to the top level.
`include "domino_tiling_counter_macros.svh"

module dtc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [dtc_pkg::TILE_W-1:0] res_tiling_count
);

	// Hold a stalled result
	`DTC_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid)
	`DTC_ASSERT_NXT(a_res_stable, res_valid && !res_ready, $stable(res_tiling_count))

	// Take no item while a result is pending
	`DTC_ASSERT_IMP(a_no_overlap, req_valid && req_ready, !res_valid)

	// Drop ready and show no result right after an item is taken
	`DTC_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready && !res_valid)

	// Deliver exactly one result per item
	`DTC_ASSERT_NXT(a_single_result, res_valid && res_ready, !res_valid)

endmodule

bind domino_tiling_counter dtc_checker u_dtc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_tiling_count (res.tiling_count)
);
